### sv/cua_pkg.sv
// Contiguous unit allocator package: op codes, strategies, states, constants.
package cua_pkg;

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_FRAG  = 2'd2,
    FUNC_CLEAR = 2'd3
  } cua_func_e;

  typedef enum logic [1:0] {
    STRAT_FIRST = 2'd0,
    STRAT_NEXT  = 2'd1,
    STRAT_BEST  = 2'd2,
    STRAT_NONE  = 2'd3
  } cua_strat_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_FILL,
    ST_CLR,
    ST_DONE
  } cua_state_e;

  localparam logic [2:0] REG_ACTIVE_UNITS = 3'd0;
  localparam int unsigned PROBE_BITS = 9;
  localparam int unsigned FRAG_BITS  = 8;

endpackage

### sv/contiguous_unit_allocator.sv
// Contiguous unit allocator: unit store, scan sequencer and APB register.
//
// Usage: the input channel (in_valid_i / in_ready_o) takes one request with
// func_i, strategy_i, request_size_i, duration_i and fragment_limit_i. Each
// request gives exactly one result on the output channel (out_valid_o /
// out_ready_o) with alloc_ok_o, probe_count_o and fragment_count_o.
// The store is one single-port-read memory with registered read data; every
// scan visits each unit by an address step and then an evaluate step.
// Allocate stops its scan at the placed hole for first and next fit (next
// fit may pass the start once more to finish a hole) and, on success, writes
// the run unit by unit; a zero size or an unknown strategy answers at once.
// Tick and fragment query scan every active unit; clear sweeps the whole
// store.
// One request is worked at a time; in_ready_o is high only while idle. A
// finished result sits in the output register, so a new request is taken
// while it waits, but that request cannot finish until the result is taken.
// After reset the block sweeps the whole store to zero before it accepts a
// request; configuration writes are taken at any time.
// The active_units register lies at byte address 0, reads back as written
// and is used saturated into 1..MEM_UNITS.
module contiguous_unit_allocator
  import cua_pkg::*;
#(
  parameter int unsigned MEM_UNITS     = 256,
  parameter int unsigned DURATION_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [1:0]  strategy_i,
  input  logic [8:0]  request_size_i,
  input  logic [7:0]  duration_i,
  input  logic [8:0]  fragment_limit_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        alloc_ok_o,
  output logic [8:0]  probe_count_o,
  output logic [7:0]  fragment_count_o
);

  localparam int unsigned AW = $clog2(MEM_UNITS);
  localparam int unsigned CW = $clog2(MEM_UNITS + 1);
  localparam int unsigned LW = (CW > 9) ? CW : 9;
  localparam logic [CW-1:0] LAST_UNIT = CW'(MEM_UNITS - 1);

  // unit store
  logic [DURATION_BITS-1:0] mem_q [MEM_UNITS];
  logic [DURATION_BITS-1:0] rd_q;
  logic                     mem_we;
  logic [AW-1:0]            mem_wa;
  logic [DURATION_BITS-1:0] mem_wd;
  logic [AW-1:0]            mem_ra;

  cua_state_e state_q, state_d;

  logic [8:0]               active_q, active_d;
  cua_func_e                op_q, op_d;
  cua_strat_e               strat_q, strat_d;
  logic [8:0]               size_q, size_d;
  logic [DURATION_BITS-1:0] dur_q, dur_d;
  logic [8:0]               limit_q, limit_d;
  logic [CW-1:0]            addr_q, addr_d;
  logic [CW-1:0]            start_q, start_d;
  logic                     segb_q, segb_d;
  logic                     in_hole_q, in_hole_d;
  logic [CW-1:0]            hpos_q, hpos_d;
  logic [CW-1:0]            hlen_q, hlen_d;
  logic                     found_q, found_d;
  logic [CW-1:0]            bpos_q, bpos_d;
  logic [CW-1:0]            blen_q, blen_d;
  logic [PROBE_BITS-1:0]    probe_q, probe_d;
  logic [FRAG_BITS-1:0]     frag_q, frag_d;
  logic                     ok_q, ok_d;
  logic [AW-1:0]            nfs_q, nfs_d;
  logic [CW-1:0]            fpos_q, fpos_d;
  logic [8:0]               fleft_q, fleft_d;
  logic                     out_valid_q, out_valid_d;
  logic                     out_ok_q, out_ok_d;
  logic [PROBE_BITS-1:0]    out_probe_q, out_probe_d;
  logic [FRAG_BITS-1:0]     out_frag_q, out_frag_d;

  // scan decision signals
  logic [CW-1:0] n_units;
  logic [LW-1:0] au_ext;
  logic          in_acc;
  logic          free_u, last_u, stop_u, open_u, close_u, fits_u, better_u;
  logic [CW-1:0] h_pos, h_len, c_pos, c_len;
  logic          place_u, found_n;
  logic [CW-1:0] bpos_n, blen_n;
  logic          to_segb, fill_best, out_free, clr_last;

  // saturate active units into 1..MEM_UNITS
  always_comb begin
    au_ext = LW'(active_q);
    if (au_ext == '0) begin
      n_units = CW'(1);
    end else if (au_ext > LW'(MEM_UNITS)) begin
      n_units = CW'(MEM_UNITS);
    end else begin
      n_units = CW'(au_ext);
    end
  end

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign clr_last = (addr_q == LAST_UNIT);

  // evaluate one unit of the scan
  always_comb begin
    free_u  = (rd_q == '0);
    last_u  = (addr_q == n_units - CW'(1));
    stop_u  = segb_q && (addr_q >= start_q) && !in_hole_q;
    open_u  = free_u && !in_hole_q;
    h_pos   = open_u ? addr_q : hpos_q;
    h_len   = open_u ? CW'(1) : hlen_q + CW'(1);
    close_u = (in_hole_q && !free_u) || (free_u && last_u);
    c_pos   = free_u ? h_pos : hpos_q;
    c_len   = free_u ? h_len : hlen_q;
    fits_u  = LW'(c_len) >= LW'(size_q);
    better_u = !found_q || (c_len < blen_q);
    place_u = (op_q == FUNC_ALLOC) && (strat_q != STRAT_BEST) && close_u && fits_u;
    found_n = found_q;
    bpos_n  = bpos_q;
    blen_n  = blen_q;
    if ((op_q == FUNC_ALLOC) && (strat_q == STRAT_BEST) && close_u && fits_u && better_u) begin
      found_n = 1'b1;
      bpos_n  = c_pos;
      blen_n  = c_len;
    end
    to_segb   = (op_q == FUNC_ALLOC) && (strat_q == STRAT_NEXT) && !segb_q &&
                (start_q != '0);
    fill_best = (op_q == FUNC_ALLOC) && (strat_q == STRAT_BEST) && found_n;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (cua_func_e'(func_i))
            FUNC_ALLOC: begin
              if (request_size_i == '0 || cua_strat_e'(strategy_i) == STRAT_NONE) begin
                state_d = ST_DONE;
              end else begin
                state_d = ST_RD;
              end
            end
            FUNC_TICK, FUNC_FRAG: state_d = ST_RD;
            FUNC_CLEAR:           state_d = ST_CLR;
            default:              state_d = ST_DONE;
          endcase
        end
      end
      ST_RD: state_d = ST_EV;
      ST_EV: begin
        if (op_q == FUNC_TICK) begin
          state_d = last_u ? ST_DONE : ST_RD;
        end else if (stop_u) begin
          state_d = ST_DONE;
        end else if (place_u) begin
          state_d = ST_FILL;
        end else if (last_u) begin
          if (to_segb) begin
            state_d = ST_RD;
          end else if (fill_best) begin
            state_d = ST_FILL;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          state_d = ST_RD;
        end
      end
      ST_FILL: begin
        if (fleft_q == 9'd1) state_d = ST_DONE;
      end
      ST_CLR: begin
        if (clr_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    active_d    = active_q;
    op_d        = op_q;
    strat_d     = strat_q;
    size_d      = size_q;
    dur_d       = dur_q;
    limit_d     = limit_q;
    addr_d      = addr_q;
    start_d     = start_q;
    segb_d      = segb_q;
    in_hole_d   = in_hole_q;
    hpos_d      = hpos_q;
    hlen_d      = hlen_q;
    found_d     = found_q;
    bpos_d      = bpos_q;
    blen_d      = blen_q;
    probe_d     = probe_q;
    frag_d      = frag_q;
    ok_d        = ok_q;
    nfs_d       = nfs_q;
    fpos_d      = fpos_q;
    fleft_d     = fleft_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_ok_d    = out_ok_q;
    out_probe_d = out_probe_q;
    out_frag_d  = out_frag_q;
    mem_we      = 1'b0;
    mem_wa      = addr_q[AW-1:0];
    mem_wd      = '0;
    mem_ra      = addr_q[AW-1:0];

    // register write
    if (psel && penable && pwrite && (paddr[2] == REG_ACTIVE_UNITS[2])) begin
      active_d = pwdata[8:0];
    end

    unique case (state_q)
      ST_INIT, ST_CLR: begin
        mem_we = 1'b1;
        nfs_d  = '0;
        addr_d = addr_q + CW'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          op_d      = cua_func_e'(func_i);
          strat_d   = cua_strat_e'(strategy_i);
          size_d    = request_size_i;
          dur_d     = DURATION_BITS'(duration_i);
          limit_d   = fragment_limit_i;
          segb_d    = 1'b0;
          in_hole_d = 1'b0;
          found_d   = 1'b0;
          probe_d   = '0;
          frag_d    = '0;
          ok_d      = 1'b0;
          start_d   = (CW'(nfs_q) < n_units) ? CW'(nfs_q) : '0;
          if ((cua_func_e'(func_i) == FUNC_ALLOC) &&
              (cua_strat_e'(strategy_i) == STRAT_NEXT)) begin
            addr_d = (CW'(nfs_q) < n_units) ? CW'(nfs_q) : '0;
          end else begin
            addr_d = '0;
          end
        end
      end
      ST_RD: ;
      ST_EV: begin
        if (op_q == FUNC_TICK) begin
          // decrement a live unit in place
          if (!free_u) begin
            mem_we = 1'b1;
            mem_wd = rd_q - DURATION_BITS'(1);
          end
          addr_d = addr_q + CW'(1);
        end else if (!stop_u) begin
          if (open_u && (op_q == FUNC_ALLOC)) begin
            probe_d = (probe_q == '1) ? probe_q : probe_q + PROBE_BITS'(1);
          end
          if ((op_q == FUNC_FRAG) && close_u && (LW'(c_len) <= LW'(limit_q))) begin
            frag_d = (frag_q == '1) ? frag_q : frag_q + FRAG_BITS'(1);
          end
          found_d   = found_n;
          bpos_d    = bpos_n;
          blen_d    = blen_n;
          hpos_d    = h_pos;
          hlen_d    = h_len;
          in_hole_d = free_u;
          addr_d    = addr_q + CW'(1);
          if (place_u) begin
            fpos_d  = c_pos;
            fleft_d = size_q;
            ok_d    = 1'b1;
          end else if (last_u) begin
            if (to_segb) begin
              addr_d    = '0;
              segb_d    = 1'b1;
              in_hole_d = 1'b0;
            end else if (fill_best) begin
              fpos_d  = bpos_n;
              fleft_d = size_q;
              ok_d    = 1'b1;
            end
          end
        end
      end
      ST_FILL: begin
        // write the run, remember its start for next fit
        mem_we  = 1'b1;
        mem_wa  = fpos_q[AW-1:0];
        mem_wd  = dur_q;
        fpos_d  = fpos_q + CW'(1);
        fleft_d = fleft_q - 9'd1;
        if (fleft_q == size_q) nfs_d = fpos_q[AW-1:0];
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ok_d    = ok_q;
          out_probe_d = probe_q;
          out_frag_d  = frag_q;
        end
      end
      default: ;
    endcase
  end

  // store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_q <= mem_q[mem_ra];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      active_q    <= 9'd256;
      addr_q      <= '0;
      nfs_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      addr_q      <= addr_d;
      nfs_q       <= nfs_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    strat_q     <= strat_d;
    size_q      <= size_d;
    dur_q       <= dur_d;
    limit_q     <= limit_d;
    start_q     <= start_d;
    segb_q      <= segb_d;
    in_hole_q   <= in_hole_d;
    hpos_q      <= hpos_d;
    hlen_q      <= hlen_d;
    found_q     <= found_d;
    bpos_q      <= bpos_d;
    blen_q      <= blen_d;
    probe_q     <= probe_d;
    frag_q      <= frag_d;
    ok_q        <= ok_d;
    fpos_q      <= fpos_d;
    fleft_q     <= fleft_d;
    out_ok_q    <= out_ok_d;
    out_probe_q <= out_probe_d;
    out_frag_q  <= out_frag_d;
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign alloc_ok_o       = out_ok_q;
  assign probe_count_o    = out_probe_q;
  assign fragment_count_o = out_frag_q;
  assign pready           = 1'b1;
  assign prdata           = (paddr[2] == REG_ACTIVE_UNITS[2]) ? {23'd0, active_q} : 32'd0;

endmodule

### sv/cua_checker.sv
// Port-level checker for the contiguous unit allocator, bound to the top level.
module cua_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       pready,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       alloc_ok_o,
  input logic [8:0] probe_count_o,
  input logic [7:0] fragment_count_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(alloc_ok_o) &&
    $stable(probe_count_o) && $stable(fragment_count_o))
    else $error("result changed while stalled");

  // a placed run was found in at least one probed hole
  a_ok_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && alloc_ok_o |-> probe_count_o != 9'd0)
    else $error("placement without a probe");

  // a successful allocate result carries no fragment count
  a_ok_frag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && alloc_ok_o |-> fragment_count_o == 8'd0)
    else $error("fragment count on an allocate");

  // the register port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind contiguous_unit_allocator cua_checker u_cua_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .pready           (pready),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .alloc_ok_o       (alloc_ok_o),
  .probe_count_o    (probe_count_o),
  .fragment_count_o (fragment_count_o)
);

### dv/testbench.sv
// Testbench for the contiguous unit allocator: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module testbench;
  import cua_pkg::*;

  typedef struct packed {
    logic       ok;
    logic [8:0] probes;
    logic [7:0] frags;
  } alloc_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i = '0;
  logic [1:0]  strategy_i = '0;
  logic [8:0]  request_size_i = '0;
  logic [7:0]  duration_i = '0;
  logic [8:0]  fragment_limit_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        alloc_ok_o;
  logic [8:0]  probe_count_o;
  logic [7:0]  fragment_count_o;

  contiguous_unit_allocator u_top (.*);

  // Predictor state
  logic [7:0]    unit_life [256];
  int unsigned   fit_start;
  logic [8:0]    active_reg;
  alloc_result_t pending_results[$];
  int unsigned   errors = 0;
  int unsigned   send_idle = 0;
  int unsigned   recv_idle = 0;

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_idle);

  function automatic int unsigned units_used();
    if (active_reg == 0) return 1;
    if (active_reg > 256) return 256;
    return active_reg;
  endfunction

  function automatic int unsigned free_run(int unsigned pos, int unsigned n);
    int unsigned len = 0;
    while (pos + len < n && unit_life[pos + len] == 0) len++;
    return len;
  endfunction

  function automatic void place(int unsigned pos, int unsigned size, logic [7:0] dur);
    for (int unsigned k = 0; k < size && pos + k < 256; k++) unit_life[pos + k] = dur;
    fit_start = pos;
  endfunction

  function automatic int unsigned bump(int unsigned v, int unsigned top);
    return v < top ? v + 1 : top;
  endfunction

  // Compute the result of one request and update the predicted store
  function automatic alloc_result_t predict_request(cua_func_e f, cua_strat_e s,
      int unsigned size, logic [7:0] dur, int unsigned limit);
    alloc_result_t r;
    int unsigned n, i, len, cnt, start, best_pos, best_len;
    bit in_hole, found;
    r = '0;
    n = units_used();
    cnt = 0;
    case (f)
      FUNC_ALLOC: begin
        if (size != 0 && s != STRAT_NONE) begin
          if (s == STRAT_FIRST) begin
            i = 0;
            while (i < n) begin
              if (unit_life[i] != 0) begin
                i++;
              end else begin
                len = free_run(i, n);
                cnt = bump(cnt, 511);
                if (len >= size) begin
                  place(i, size, dur);
                  r.ok = 1'b1;
                  break;
                end
                i += len;
              end
            end
          end else if (s == STRAT_NEXT) begin
            start = fit_start < n ? fit_start : 0;
            in_hole = 0;
            for (int unsigned k = 0; k < n; k++) begin
              i = start + k;
              if (i >= n) i -= n;
              if (i == 0) in_hole = 0;
              if (unit_life[i] != 0) begin
                in_hole = 0;
              end else if (!in_hole) begin
                cnt = bump(cnt, 511);
                if (free_run(i, n) >= size) begin
                  place(i, size, dur);
                  r.ok = 1'b1;
                  break;
                end
                in_hole = 1;
              end
            end
          end else begin
            found = 0;
            best_pos = 0;
            best_len = 0;
            i = 0;
            while (i < n) begin
              if (unit_life[i] != 0) begin
                i++;
              end else begin
                len = free_run(i, n);
                cnt = bump(cnt, 511);
                if (len >= size && (!found || len < best_len)) begin
                  found = 1;
                  best_pos = i;
                  best_len = len;
                end
                i += len;
              end
            end
            if (found) begin
              place(best_pos, size, dur);
              r.ok = 1'b1;
            end
          end
          r.probes = 9'(cnt);
        end
      end
      FUNC_TICK: begin
        for (int unsigned k = 0; k < n; k++)
          if (unit_life[k] != 0) unit_life[k]--;
      end
      FUNC_FRAG: begin
        i = 0;
        while (i < n) begin
          if (unit_life[i] != 0) begin
            i++;
          end else begin
            len = free_run(i, n);
            if (len <= limit) cnt = bump(cnt, 255);
            i += len;
          end
        end
        r.frags = 8'(cnt);
      end
      default: begin
        for (int unsigned k = 0; k < 256; k++) unit_life[k] = 0;
        fit_start = 0;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Check each result against the oldest pending prediction
  always @(posedge clk_i) begin
    alloc_result_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        w = pending_results.pop_front();
        if (alloc_ok_o !== w.ok) report_mismatch("alloc_ok", alloc_ok_o, w.ok);
        if (probe_count_o !== w.probes) report_mismatch("probe_count", probe_count_o, w.probes);
        if (fragment_count_o !== w.frags)
          report_mismatch("fragment_count", fragment_count_o, w.frags);
      end
    end
  end

  // Send one request; called and returning at a falling edge
  task automatic send_request(cua_func_e f, cua_strat_e s, logic [8:0] size,
      logic [7:0] dur, logic [8:0] limit);
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    func_i           <= f;
    strategy_i       <= s;
    request_size_i   <= size;
    duration_i       <= dur;
    fragment_limit_i <= limit;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_request(f, s, size, dur, limit));
    @(negedge clk_i);
  endtask

  // Drop valid and wait for every pending result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == REG_ACTIVE_UNITS) active_reg = data[8:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_directed();
    apb_write(REG_ACTIVE_UNITS, 256);
    send_request(FUNC_FRAG,  STRAT_FIRST, 0,   0,   0);
    send_request(FUNC_FRAG,  STRAT_FIRST, 0,   0,   256);
    send_request(FUNC_ALLOC, STRAT_FIRST, 0,   5,   0);
    send_request(FUNC_ALLOC, STRAT_NONE,  4,   5,   0);
    send_request(FUNC_ALLOC, STRAT_FIRST, 511, 9,   0);
    send_request(FUNC_ALLOC, STRAT_FIRST, 256, 2,   0);
    send_request(FUNC_ALLOC, STRAT_BEST,  1,   3,   0);
    send_request(FUNC_TICK,  STRAT_FIRST, 0,   0,   0);
    send_request(FUNC_TICK,  STRAT_FIRST, 0,   0,   0);
    send_request(FUNC_CLEAR, STRAT_NONE,  0,   0,   0);
    send_request(FUNC_ALLOC, STRAT_NEXT,  10,  255, 0);
    send_request(FUNC_ALLOC, STRAT_FIRST, 5,   1,   0);
    send_request(FUNC_ALLOC, STRAT_NEXT,  20,  128, 0);
    send_request(FUNC_TICK,  STRAT_FIRST, 0,   0,   0);
    send_request(FUNC_ALLOC, STRAT_BEST,  3,   7,   0);
    send_request(FUNC_ALLOC, STRAT_NEXT,  4,   0,   0);
    send_request(FUNC_FRAG,  STRAT_FIRST, 0,   0,   5);
    send_request(FUNC_FRAG,  STRAT_FIRST, 0,   0,   511);
    send_request(FUNC_ALLOC, STRAT_NEXT,  250, 6,   0);
    drain();
    // Smallest store, including the zero setting that saturates to one unit
    apb_write(REG_ACTIVE_UNITS, 0);
    send_request(FUNC_ALLOC, STRAT_NEXT,  1,   4,   0);
    send_request(FUNC_ALLOC, STRAT_FIRST, 1,   4,   0);
    send_request(FUNC_FRAG,  STRAT_FIRST, 0,   0,   1);
    send_request(FUNC_CLEAR, STRAT_FIRST, 0,   0,   0);
    send_request(FUNC_ALLOC, STRAT_BEST,  2,   4,   1);
    drain();
  endtask

  task automatic test_random(int unsigned items, logic [31:0] active);
    int unsigned n, pick, size, lim;
    cua_func_e  f;
    cua_strat_e s;
    apb_write(REG_ACTIVE_UNITS, active);
    n = units_used();
    for (int unsigned it = 0; it < items; it++) begin
      pick = $urandom_range(99);
      if (pick < 55) f = FUNC_ALLOC;
      else if (pick < 77) f = FUNC_TICK;
      else if (pick < 95) f = FUNC_FRAG;
      else f = FUNC_CLEAR;
      s = cua_strat_e'($urandom_range(99) < 5 ? 3 : $urandom_range(2));
      if ($urandom_range(99) < 8) size = $urandom_range(511);
      else size = $urandom_range(1, n / 4 + 1);
      if ($urandom_range(99) < 10) lim = $urandom_range(511);
      else lim = $urandom_range(n);
      send_request(f, s, 9'(size), 8'($urandom_range(255)), 9'(lim));
    end
    drain();
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    active_reg = 256;
    fit_start = 0;
    for (int k = 0; k < 256; k++) unit_life[k] = 0;
    @(negedge clk_i);

    send_idle = 24;
    recv_idle = 47;
    test_directed();
    test_random(150, 256);
    test_random(150, 16);
    send_idle = 47;
    recv_idle = 24;
    test_random(150, 37);
    test_random(100, 1);
    test_random(150, 300);
    send_idle = 0;
    recv_idle = 0;
    test_random(150, 511);
    test_random(150, 64);

    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

### filelist.f
sv/cua_pkg.sv
sv/contiguous_unit_allocator.sv
sv/cua_checker.sv
dv/testbench.sv
